/* hdl/u16u8_pkg.sv */
// Shared types, constants and the UTF-8 byte builder for the UTF-16 to UTF-8 encoder.
// No dependencies; every other file in hdl imports this package.
package u16u8_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_END    = 16'hE000;
  localparam logic [15:0] REPL_CHAR  = 16'hFFFD;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  // UTF-8 form of U+FFFD.
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // Encoded character: byte count and bytes, element 0 leaves first.
  typedef struct packed {
    logic [2:0]      cnt;
    logic [3:0][7:0] bytes;
  } enc_t;

  // One unit of work for the byte emitter.
  typedef struct packed {
    logic            repl;
    logic [2:0]      cnt;
    logic [3:0][7:0] bytes;
  } job_t;

  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.cnt      = 3'd1;
      e.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      e.cnt      = 3'd2;
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.cnt      = 3'd3;
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      e.cnt      = 3'd4;
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage

/* hdl/utf16_to_utf8_encoder.sv */
// UTF-16 to UTF-8 encoder top level. The first byte of a word reaches the result ports
// through the job queue, the emitter's current-job register and its output register.
// Throughput: one output byte per cycle while the receiver pops; a word causes zero to
// six bytes (none for a fresh high surrogate); the output register sets that rate.
// Reset (rst, synchronous, active high) clears the pending surrogate, queue and output.
// Depends on u16u8_pkg, u16u8_front, u16u8_fifo and u16u8_back.
module utf16_to_utf8_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] code_unit,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last_byte
);
  import u16u8_pkg::*;

  // The front end classifies each word and hands a job to the queue. Words that
  // produce nothing (a fresh high surrogate) never occupy a queue entry.
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_valid;
  job_t job;
  job_t q_head;

  // Input side stalls only when the job queue has no room.
  assign full = q_full;

  u16u8_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .code_unit (code_unit),
    .q_full    (q_full),
    .q_push    (q_push),
    .job       (job)
  );

  // Two-entry queue lets the front keep taking words while bytes drain.
  u16u8_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .din       (job),
    .pop       (q_pop),
    .dout      (q_head),
    .full      (q_full),
    .not_empty (q_valid)
  );

  // The emitter picks up the next job in the same cycle the last byte of the
  // current one moves into the output register, so bytes flow without gaps.
  u16u8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

  // The queue must never be written while it is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job queue written while full");

  // Every queued job must carry at least one byte.
  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (job.repl || (job.cnt != 3'd0)))
    else $error("job with no bytes queued");

  // A job is taken only when one is present.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("job queue read while empty");

  // Reset leaves nothing on the result side.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result present right after reset");

endmodule

/* hdl/u16u8_front.sv */
// Front end: accepts UTF-16 code units, tracks a pending high surrogate and
// builds a job for each unit that yields bytes. Depends on u16u8_pkg.
module u16u8_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [15:0]         code_unit,
  input  logic                q_full,
  output logic                q_push,
  output u16u8_pkg::job_t     job
);
  import u16u8_pkg::*;

  logic        held_valid;
  logic [9:0]  held_high;
  logic        take;
  logic        is_high;
  logic        is_low;
  logic        pair;
  logic [20:0] cp;
  enc_t        enc;

  assign take    = push && !q_full;
  assign is_high = (code_unit >= HIGH_FIRST) && (code_unit < LOW_FIRST);
  assign is_low  = (code_unit >= LOW_FIRST) && (code_unit < LOW_END);
  assign pair    = held_valid && is_low;

  always_comb begin
    if (pair) begin
      cp = SUPP_BASE + {1'b0, held_high, code_unit[9:0]};
    end else if (is_low) begin
      cp = {5'd0, REPL_CHAR};
    end else begin
      cp = {5'd0, code_unit};
    end
    enc       = utf8_encode(cp);
    job.repl  = held_valid && !is_low;
    job.cnt   = is_high ? 3'd0 : enc.cnt;
    job.bytes = enc.bytes;
  end

  // A high surrogate with nothing pending produces no bytes and no job.
  assign q_push = take && (job.repl || (job.cnt != 3'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_high  <= '0;
    end else if (take) begin
      if (is_high) begin
        held_valid <= 1'b1;
        held_high  <= code_unit[9:0];
      end else begin
        held_valid <= 1'b0;
        held_high  <= '0;
      end
    end
  end

endmodule

/* hdl/u16u8_fifo.sv */
// Short job queue between the front end and the byte emitter.
// Depends on u16u8_pkg for the job type and depth.
module u16u8_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  u16u8_pkg::job_t     din,
  input  logic                pop,
  output u16u8_pkg::job_t     dout,
  output logic                full,
  output logic                not_empty
);
  import u16u8_pkg::*;

  job_t           store [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QCW-1:0] count;

  assign full      = (count == QCW'(QDEPTH));
  assign not_empty = (count != '0);
  assign dout      = store[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QAW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QAW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/u16u8_back.sv */
// Byte emitter: walks each job one byte per cycle into an output register
// while the receiver pops or the register is empty. Depends on u16u8_pkg.
module u16u8_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  u16u8_pkg::job_t     q_head,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output logic [7:0]          out_byte,
  output logic                last_byte
);
  import u16u8_pkg::*;

  logic            cur_valid;
  job_t            cur;
  logic [2:0]      pos;
  logic            out_valid;
  logic [5:0][7:0] seq;
  logic [2:0]      total;
  logic            advance;
  logic            cur_last;

  // Byte sequence of the current job: U+FFFD first when flagged.
  always_comb begin
    seq = '0;
    if (cur.repl) begin
      seq[0] = REPL_B0;
      seq[1] = REPL_B1;
      seq[2] = REPL_B2;
      seq[3] = cur.bytes[0];
      seq[4] = cur.bytes[1];
      seq[5] = cur.bytes[2];
      total  = cur.cnt + 3'd3;
    end else begin
      seq[0] = cur.bytes[0];
      seq[1] = cur.bytes[1];
      seq[2] = cur.bytes[2];
      seq[3] = cur.bytes[3];
      total  = cur.cnt;
    end
  end

  assign advance  = !out_valid || pop;
  assign cur_last = cur_valid && (pos == total - 3'd1);
  assign q_pop    = q_valid && (!cur_valid || (advance && cur_last));
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (advance && cur_valid) begin
      out_byte  <= seq[pos];
      last_byte <= cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= cur_valid;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
        pos       <= '0;
      end else if (advance && cur_valid) begin
        if (cur_last) begin
          cur_valid <= 1'b0;
          pos       <= '0;
        end else begin
          pos <= pos + 3'd1;
        end
      end
    end
  end

endmodule

/* dv/tb_utf16_to_utf8_encoder.sv */
// Self-checking testbench for utf16_to_utf8_encoder: drives UTF-16 code units and checks
// every emitted UTF-8 byte and its last-byte flag against a predictor of its own.
// Depends on u16u8_pkg and the encoder RTL in hdl.
module tb_utf16_to_utf8_encoder;

  timeunit 1ns;
  timeprecision 1ps;

  import u16u8_pkg::*;

  // Longest run of cycles with no word moving on either side before the run is declared hung.
  // The deliberate receiver hold, HOLD_CYCLES, is far shorter, so this leaves a wide margin.
  localparam int IDLE_LIMIT   = 1000;
  localparam int HOLD_CYCLES  = 120;
  localparam int RANDOM_WORDS = 200;
  // Extra wait after the last expected byte arrives, to catch any bytes beyond it.
  localparam int DRAIN_CYCLES = 10;

  // Predicts the byte stream. It keeps its own copy of the pending high surrogate and a
  // queue of expected bytes, each packed as {last flag, byte}.
  class utf8_scoreboard;
    logic [9:0]  held_bits;
    bit          held;
    logic [7:0]  char_bytes[$];
    logic [8:0]  expected_bytes[$];
    int          errors;

    // Appends the UTF-8 form of one scalar value to the bytes of the current word.
    function void add_char(input logic [20:0] cp);
      if (cp < 21'h80) begin
        char_bytes.push_back({1'b0, cp[6:0]});
      end else if (cp < 21'h800) begin
        char_bytes.push_back({3'b110, cp[10:6]});
        char_bytes.push_back({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
        char_bytes.push_back({4'b1110, cp[15:12]});
        char_bytes.push_back({2'b10, cp[11:6]});
        char_bytes.push_back({2'b10, cp[5:0]});
      end else begin
        char_bytes.push_back({5'b11110, cp[20:18]});
        char_bytes.push_back({2'b10, cp[17:12]});
        char_bytes.push_back({2'b10, cp[11:6]});
        char_bytes.push_back({2'b10, cp[5:0]});
      end
    endfunction

    // Called once per accepted word: works out the bytes it causes.
    function void note_word(input logic [15:0] cu);
      bit is_high;
      bit is_low;
      is_high = (cu >= HIGH_FIRST) && (cu < LOW_FIRST);
      is_low  = (cu >= LOW_FIRST) && (cu < LOW_END);
      char_bytes.delete();
      if (held && is_low) begin
        // A surrogate pair completes a supplementary character.
        add_char(SUPP_BASE + {1'b0, held_bits, cu[9:0]});
        held = 0;
        held_bits = '0;
      end else begin
        // Anything but a low surrogate orphans a held high surrogate.
        if (held) begin
          add_char({5'd0, REPL_CHAR});
          held = 0;
          held_bits = '0;
        end
        if (is_high) begin
          held_bits = cu[9:0];
          held = 1;
        end else if (is_low) begin
          add_char({5'd0, REPL_CHAR});
        end else begin
          add_char({5'd0, cu});
        end
      end
      foreach (char_bytes[i])
        expected_bytes.push_back({(i == char_bytes.size() - 1), char_bytes[i]});
    endfunction

    // Called once per accepted result: compares it with the oldest expected byte.
    function void check_byte(input logic [7:0] b, input logic last);
      logic [8:0] exp_val;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual byte %02h last %0b",
                 $time, b, last);
        errors++;
        return;
      end
      exp_val = expected_bytes.pop_front();
      if (b !== exp_val[7:0]) begin
        $display("%0t: out_byte: expected %02h, actual %02h", $time, exp_val[7:0], b);
        errors++;
      end
      if (last !== exp_val[8]) begin
        $display("%0t: last_byte: expected %0b, actual %0b", $time, exp_val[8], last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [15:0] code_unit;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        last_byte;

  utf8_scoreboard sb = new();

  int burst_left = 0;
  bit hold_req   = 0;
  int idle_count = 0;

  utf16_to_utf8_encoder uut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .code_unit (code_unit),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both handshakes are sampled at the rising edge, before any of this edge's nonblocking
  // updates land, so the monitor sees the values that the block itself saw. The same
  // block runs the watchdog on cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full)
        sb.note_word(code_unit);
      if (pop && !empty)
        sb.check_byte(out_byte, last_byte);
      if ((push && !full) || (pop && !empty)) begin
        idle_count <= 0;
      end else begin
        idle_count <= idle_count + 1;
        if (idle_count + 1 >= IDLE_LIMIT) begin
          $display("utf16_to_utf8_encoder: mismatch");
          $finish;
        end
      end
    end
  end

  // Offers one word and returns once it has been accepted. The sender works in bursts:
  // when a burst runs out it may drop push for a random gap, though often there is none,
  // so back-to-back stretches happen too.
  task automatic send_word(input logic [15:0] cu);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    push      <= 1'b1;
    code_unit <= cu;
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
  endtask

  // Random part: mostly well-formed text with surrogate pairs in it, plus lone and broken
  // surrogates and fully random units.
  task automatic run_random();
    int sel;
    int sent;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        send_word(16'($urandom_range(16'hD800, 16'hDBFF)));
        send_word(16'($urandom_range(16'hDC00, 16'hDFFF)));
        sent += 2;
      end else if (sel < 55) begin
        send_word(16'($urandom_range(16'h0000, 16'h007F)));
        sent++;
      end else if (sel < 68) begin
        send_word(16'($urandom_range(16'h0080, 16'h07FF)));
        sent++;
      end else if (sel < 80) begin
        if ($urandom_range(0, 1))
          send_word(16'($urandom_range(16'h0800, 16'hD7FF)));
        else
          send_word(16'($urandom_range(16'hE000, 16'hFFFF)));
        sent++;
      end else if (sel < 86) begin
        send_word(16'($urandom_range(16'hDC00, 16'hDFFF)));
        sent++;
      end else if (sel < 92) begin
        // A high surrogate followed by anything at all, often not a low one.
        send_word(16'($urandom_range(16'hD800, 16'hDBFF)));
        send_word(16'($urandom()));
        sent += 2;
      end else begin
        send_word(16'($urandom()));
        sent++;
      end
    end
  endtask

  // Receiver: pop follows one of several patterns, each kept for a random stretch. When
  // the stimulus asks for it, pop is held low for a long count so that the block fills
  // up and pushes back on the sender.
  initial begin
    int mode;
    int seg;
    logic [7:0] mask;
    int ph;
    wait (rst === 1'b0);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(20, 60);
        mask = 8'($urandom());
        ph   = 0;
        repeat (seg) begin
          case (mode)
            0: begin
              pop <= 1'b1;
            end
            1: begin
              pop <= 1'($urandom_range(0, 1));
            end
            2: begin
              pop <= mask[ph % 8];
              ph++;
            end
            default: begin
              pop <= ($urandom_range(0, 3) == 0);
            end
          endcase
          @(posedge clk);
          if (hold_req) break;
        end
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    push      <= 1'b0;
    pop       <= 1'b0;
    code_unit <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: the edges of each UTF-8 length, NUL, the replacement character
    // itself, the lowest and highest surrogate pairs, lone low surrogates, a high
    // surrogate displaced by another, and orphaned highs followed by a letter, by a
    // three-byte unit (the six-byte case) and by NUL.
    send_word(16'h0000);
    send_word(16'h007F);
    send_word(16'h0080);
    send_word(16'h07FF);
    send_word(16'h0800);
    send_word(16'hFFFF);
    send_word(16'hFFFD);
    send_word(16'hD800);
    send_word(16'hDC00);
    send_word(16'hDBFF);
    send_word(16'hDFFF);
    send_word(16'hDC00);
    send_word(16'hDFFF);
    send_word(16'hD800);
    send_word(16'hD801);
    send_word(16'h0041);
    send_word(16'hDBFF);
    send_word(16'hFFFF);
    send_word(16'hD7FF);
    send_word(16'hE000);
    send_word(16'hDA00);
    send_word(16'h0000);
    send_word(16'hD9AB);
    send_word(16'hDE12);

    // The long receiver hold lands at the start of the random part, while words keep
    // coming.
    hold_req = 1;
    run_random();
    push <= 1'b0;

    // Wait for every expected byte, then DRAIN_CYCLES more to catch any extra ones.
    // A byte that never comes is caught by the watchdog.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("utf16_to_utf8_encoder: match");
    end else begin
      $display("utf16_to_utf8_encoder: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/u16u8_pkg.sv
hdl/u16u8_front.sv
hdl/u16u8_fifo.sv
hdl/u16u8_back.sv
hdl/utf16_to_utf8_encoder.sv
dv/tb_utf16_to_utf8_encoder.sv
